/* hdl/ecdc_pkg.sv */
// ============================================================================
// ecdc_pkg - epoch ms / civil date converter shared types and constants
// Beat layouts for both directions, calendar constants, reciprocal
// multipliers for the constant divisions and the month offset table.
// ============================================================================
package ecdc_pkg;

	typedef struct packed {
		logic        op;
		logic [47:0] epoch_ms_in;
		logic [13:0] year_in;
		logic [3:0]  month_in;
		logic [4:0]  day_in;
		logic [4:0]  hour_in;
		logic [5:0]  minute_in;
		logic [5:0]  second_in;
	} cmd_t;

	typedef struct packed {
		logic [13:0] year_out;
		logic [3:0]  month_out;
		logic [4:0]  day_out;
		logic [4:0]  hour_out;
		logic [5:0]  minute_out;
		logic [5:0]  second_out;
		logic [2:0]  weekday_out;
		logic [47:0] epoch_ms_out;
	} rsp_t;

	localparam logic OP_TO_CIVIL = 1'b0;
	localparam logic OP_TO_EPOCH = 1'b1;

	// start to done
	localparam int unsigned LATENCY = 15;

	localparam logic [26:0] MS_PER_DAY   = 27'd86400000;
	localparam logic [21:0] MS_PER_HOUR  = 22'd3600000;
	localparam logic [15:0] MS_PER_MIN   = 16'd60000;
	localparam logic [9:0]  MS_PER_SEC   = 10'd1000;
	localparam logic [16:0] DAY_DIV      = 17'd84375;   // MS_PER_DAY / 1024
	localparam logic [19:0] DAYS_SHIFT   = 20'd719468;
	localparam logic [17:0] ERA_DAYS     = 18'd146097;
	localparam logic [8:0]  YEAR_DAYS    = 9'd365;
	localparam logic [8:0]  ERA_YEARS    = 9'd400;
	localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
	localparam logic [5:0]  SEC_PER_MIN  = 6'd60;
	// era bias (one era) plus day shift plus one for the 1-based day sum
	localparam logic [19:0] DAY_BIAS     = 20'd865566;

	// Exact reciprocals: M = ceil(2^K / D) with K = N + ceil(log2 D) for an
	// N-bit dividend, so floor(x * M / 2^K) == floor(x / D) for all x.
	localparam int unsigned DAY_K = 55;
	localparam logic [38:0] DAY_M =
		39'(((64'd1 << DAY_K) + 64'd84374) / 64'd84375);
	localparam int unsigned ERA_K = 40;
	localparam logic [22:0] ERA_M =
		23'(((64'd1 << ERA_K) + 64'd146096) / 64'd146097);
	localparam int unsigned WD_K = 25;
	localparam logic [22:0] WD_M = 23'(((64'd1 << WD_K) + 64'd6) / 64'd7);
	localparam int unsigned SOD_K = 31;
	localparam logic [24:0] SOD_M = 25'(((64'd1 << SOD_K) + 64'd124) / 64'd125);
	localparam int unsigned HR_K = 29;
	localparam logic [17:0] HR_M = 18'(((64'd1 << HR_K) + 64'd3599) / 64'd3600);
	localparam int unsigned MIN_K = 18;
	localparam logic [12:0] MIN_M = 13'(((64'd1 << MIN_K) + 64'd59) / 64'd60);
	localparam int unsigned Q1460_K = 29;
	localparam logic [18:0] Q1460_M =
		19'(((64'd1 << Q1460_K) + 64'd1459) / 64'd1460);
	localparam int unsigned Q36524_K = 34;
	localparam logic [18:0] Q36524_M =
		19'(((64'd1 << Q36524_K) + 64'd36523) / 64'd36524);
	localparam int unsigned Q146096_K = 36;
	localparam logic [18:0] Q146096_M =
		19'(((64'd1 << Q146096_K) + 64'd146095) / 64'd146096);
	localparam int unsigned YOE_K = 27;
	localparam logic [18:0] YOE_M = 19'(((64'd1 << YOE_K) + 64'd364) / 64'd365);
	localparam int unsigned C100_K = 16;
	localparam logic [9:0]  C100_M = 10'(((64'd1 << C100_K) + 64'd99) / 64'd100);
	localparam int unsigned MP_K = 19;
	localparam logic [11:0] MP_M = 12'(((64'd1 << MP_K) + 64'd152) / 64'd153);
	localparam int unsigned CIV100_K = 22;
	localparam logic [15:0] CIV100_M =
		16'(((64'd1 << CIV100_K) + 64'd99) / 64'd100);

	// (153 * mi + 2) / 5: first day-of-year of March-based month index mi
	function automatic logic [8:0] doy_start(input logic [3:0] mi);
		logic [8:0] r;
		case (mi)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			4'd12:   r = 9'd367;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

/* hdl/ecdc_to_civil.sv */
// ============================================================================
// ecdc_to_civil - epoch milliseconds to civil date and time
// Fifteen-stage datapath: day count and time of day by reciprocal
// multiplication, then era / year-of-era / day-of-year / month split.
// ============================================================================
module ecdc_to_civil (
	input  logic        clk,
	input  logic [47:0] epoch_ms,
	output logic [13:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second,
	output logic [2:0]  weekday
);

	// ms >> 10, divided by 84375, gives the day count
	logic [37:0] x_ms;
	assign x_ms = epoch_ms[47:10];

	logic [37:0] p_hh_s1, p_lh_s1;
	logic [38:0] p_hl_s1, p_ll_s1;
	logic [23:0] msl_s1, msl_s2, msl_s3, msl_s4;
	logic [56:0] a_s2;
	logic [57:0] b_s2;
	logic [76:0] day_prod;
	logic [21:0] days_s3;
	logic [21:0] z_s4, z_s5, z_s6;
	logic [21:0] wdx_s4;
	logic [38:0] remp_full;
	logic [16:0] remp_s4;
	logic [44:0] era_p_s5, wd_p_s5;
	logic [2:0]  wdx_s5;
	logic [23:0] sodx_s5;
	logic [4:0]  era_s6, era_s7, era_s8, era_s9, era_s10, era_s11;
	logic [2:0]  wd_s6, wd_s7, wd_s8, wd_s9, wd_s10, wd_s11, wd_s12, wd_s13, wd_s14;
	logic [19:0] wd_q;
	logic [48:0] sod_p_s6;
	logic [22:0] era_days;
	logic [17:0] doe_s7, doe_s8, doe_s9, doe_s10, doe_s11, doe_s12;
	logic [16:0] sod_s7, sod_s8;
	logic [36:0] q1_p_s8, q2_p_s8, q3_p_s8;
	logic [34:0] hr_p_s8;
	logic [17:0] yn_s9;
	logic [4:0]  hr;
	logic [16:0] hr_secs;
	logic [4:0]  hour_s9, hour_s10, hour_s11, hour_s12, hour_s13, hour_s14;
	logic [11:0] msec_s9, msec_s10;
	logic [36:0] yoe_p_s10;
	logic [24:0] min_p_s10;
	logic [8:0]  yoe_s11;
	logic [5:0]  min_q;
	logic [11:0] min_secs;
	logic [5:0]  minute_s11, minute_s12, minute_s13, minute_s14;
	logic [5:0]  second_s11, second_s12, second_s13, second_s14;
	logic [18:0] y100_p_s12;
	logic [17:0] t_s12;
	logic [13:0] yfull_s12, yfull_s13, yfull_s14;
	logic [8:0]  doy_s13, doy_s14;
	logic [10:0] mpx;
	logic [22:0] mp_p_s14;
	logic [3:0]  mp;
	logic [13:0] year_s15;
	logic [3:0]  month_s15;
	logic [4:0]  day_s15;
	logic [4:0]  hour_s15;
	logic [5:0]  minute_s15, second_s15;
	logic [2:0]  weekday_s15;

	assign day_prod  = {a_s2, 20'd0} + 77'(b_s2);
	assign remp_full = 39'(days_s3) * 39'(ecdc_pkg::DAY_DIV);
	assign wd_q      = wd_p_s5[ecdc_pkg::WD_K +: 20];
	assign era_days  = 23'(era_s6) * 23'(ecdc_pkg::ERA_DAYS);
	assign hr        = hr_p_s8[ecdc_pkg::HR_K +: 5];
	assign hr_secs   = 17'(hr) * 17'(ecdc_pkg::SEC_PER_HOUR);
	assign min_q     = min_p_s10[ecdc_pkg::MIN_K +: 6];
	assign min_secs  = 12'(min_q) * 12'(ecdc_pkg::SEC_PER_MIN);
	assign mpx       = {doy_s13, 2'b00} + 11'(doy_s13) + 11'd2;
	assign mp        = mp_p_s14[ecdc_pkg::MP_K +: 4];

	always_ff @(posedge clk) begin
		// s1: partial products of x * M for the day count
		p_hh_s1 <= 38'(x_ms[37:19]) * 38'(ecdc_pkg::DAY_M[38:20]);
		p_hl_s1 <= 39'(x_ms[37:19]) * 39'(ecdc_pkg::DAY_M[19:0]);
		p_lh_s1 <= 38'(x_ms[18:0]) * 38'(ecdc_pkg::DAY_M[38:20]);
		p_ll_s1 <= 39'(x_ms[18:0]) * 39'(ecdc_pkg::DAY_M[19:0]);
		msl_s1  <= epoch_ms[26:3];

		// s2: x * M_hi and x * M_lo
		a_s2   <= {p_hh_s1, 19'd0} + 57'(p_lh_s1);
		b_s2   <= {p_hl_s1, 19'd0} + 58'(p_ll_s1);
		msl_s2 <= msl_s1;

		// s3
		days_s3 <= day_prod[ecdc_pkg::DAY_K +: 22];
		msl_s3  <= msl_s2;

		// s4: remainder only needs the low 17 bits, it is below 84375
		z_s4    <= days_s3 + 22'(ecdc_pkg::DAYS_SHIFT);
		wdx_s4  <= days_s3 + 22'd4;
		remp_s4 <= remp_full[16:0];
		msl_s4  <= msl_s3;

		// s5
		era_p_s5 <= 45'(z_s4) * 45'(ecdc_pkg::ERA_M);
		wd_p_s5  <= 45'(wdx_s4) * 45'(ecdc_pkg::WD_M);
		wdx_s5   <= wdx_s4[2:0];
		sodx_s5  <= {msl_s4[23:7] - remp_s4, msl_s4[6:0]};
		z_s5     <= z_s4;

		// s6: x - 7q == x + q mod 8, and the result is below 7
		era_s6   <= era_p_s5[ecdc_pkg::ERA_K +: 5];
		wd_s6    <= wdx_s5 + wd_q[2:0];
		sod_p_s6 <= 49'(sodx_s5) * 49'(ecdc_pkg::SOD_M);
		z_s6     <= z_s5;

		// s7
		doe_s7 <= z_s6[17:0] - era_days[17:0];
		sod_s7 <= sod_p_s6[ecdc_pkg::SOD_K +: 17];
		era_s7 <= era_s6;
		wd_s7  <= wd_s6;

		// s8
		q1_p_s8 <= 37'(doe_s7) * 37'(ecdc_pkg::Q1460_M);
		q2_p_s8 <= 37'(doe_s7) * 37'(ecdc_pkg::Q36524_M);
		q3_p_s8 <= 37'(doe_s7) * 37'(ecdc_pkg::Q146096_M);
		hr_p_s8 <= 35'(sod_s7) * 35'(ecdc_pkg::HR_M);
		doe_s8  <= doe_s7;
		sod_s8  <= sod_s7;
		era_s8  <= era_s7;
		wd_s8   <= wd_s7;

		// s9: leap-day corrected day-of-era before the /365
		yn_s9   <= doe_s8 - 18'(q1_p_s8[ecdc_pkg::Q1460_K +: 8])
		           + 18'(q2_p_s8[ecdc_pkg::Q36524_K +: 3])
		           - 18'(q3_p_s8[ecdc_pkg::Q146096_K +: 1]);
		hour_s9 <= hr;
		msec_s9 <= sod_s8[11:0] - hr_secs[11:0];
		doe_s9  <= doe_s8;
		era_s9  <= era_s8;
		wd_s9   <= wd_s8;

		// s10
		yoe_p_s10 <= 37'(yn_s9) * 37'(ecdc_pkg::YOE_M);
		min_p_s10 <= 25'(msec_s9) * 25'(ecdc_pkg::MIN_M);
		hour_s10  <= hour_s9;
		msec_s10  <= msec_s9;
		doe_s10   <= doe_s9;
		era_s10   <= era_s9;
		wd_s10    <= wd_s9;

		// s11
		yoe_s11    <= yoe_p_s10[ecdc_pkg::YOE_K +: 9];
		minute_s11 <= min_q;
		second_s11 <= msec_s10[5:0] - min_secs[5:0];
		hour_s11   <= hour_s10;
		doe_s11    <= doe_s10;
		era_s11    <= era_s10;
		wd_s11     <= wd_s10;

		// s12
		y100_p_s12 <= 19'(yoe_s11) * 19'(ecdc_pkg::C100_M);
		t_s12      <= 18'(yoe_s11) * 18'(ecdc_pkg::YEAR_DAYS) + 18'(yoe_s11[8:2]);
		yfull_s12  <= 14'(yoe_s11) + 14'(era_s11) * 14'(ecdc_pkg::ERA_YEARS);
		doe_s12    <= doe_s11;
		hour_s12   <= hour_s11;
		minute_s12 <= minute_s11;
		second_s12 <= second_s11;
		wd_s12     <= wd_s11;

		// s13
		doy_s13    <= 9'(doe_s12 - t_s12 + 18'(y100_p_s12[ecdc_pkg::C100_K +: 3]));
		yfull_s13  <= yfull_s12;
		hour_s13   <= hour_s12;
		minute_s13 <= minute_s12;
		second_s13 <= second_s12;
		wd_s13     <= wd_s12;

		// s14
		mp_p_s14   <= 23'(mpx) * 23'(ecdc_pkg::MP_M);
		doy_s14    <= doy_s13;
		yfull_s14  <= yfull_s13;
		hour_s14   <= hour_s13;
		minute_s14 <= minute_s13;
		second_s14 <= second_s13;
		wd_s14     <= wd_s13;

		// s15: January and February belong to the next civil year
		day_s15     <= 5'(doy_s14 - ecdc_pkg::doy_start(mp) + 9'd1);
		month_s15   <= (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
		year_s15    <= yfull_s14 + 14'(mp >= 4'd10);
		hour_s15    <= hour_s14;
		minute_s15  <= minute_s14;
		second_s15  <= second_s14;
		weekday_s15 <= wd_s14;
	end

	assign year    = year_s15;
	assign month   = month_s15;
	assign day     = day_s15;
	assign hour    = hour_s15;
	assign minute  = minute_s15;
	assign second  = second_s15;
	assign weekday = weekday_s15;

endmodule

/* hdl/ecdc_to_epoch.sv */
// ============================================================================
// ecdc_to_epoch - civil date and time to epoch milliseconds
// Closed-form day count on a year biased by one era, times ms per day,
// plus time of day, saturated to 48 bits; delayed to the common latency.
// ============================================================================
module ecdc_to_epoch (
	input  logic        clk,
	input  logic [13:0] year,
	input  logic [3:0]  month,
	input  logic [4:0]  day,
	input  logic [4:0]  hour,
	input  logic [5:0]  minute,
	input  logic [5:0]  second,
	output logic [47:0] epoch
);

	localparam int unsigned DLY = 8;
	localparam logic signed [27:0] MS_PER_DAY_S = $signed({1'b0, ecdc_pkg::MS_PER_DAY});

	logic        le2;
	logic [3:0]  mi;
	logic [14:0] y2_s1;
	logic [8:0]  doyp_s1, doyp_s2;
	logic [26:0] hms_s1;
	logic [21:0] mms_s1;
	logic [15:0] sms_s1;
	logic [30:0] cp_s2;
	logic [22:0] base_s2;
	logic [12:0] y4_s2;
	logic [26:0] tod_s2, tod_s3, tod_s4, tod_s5;
	logic [7:0]  c_s3;
	logic [22:0] pre_s3;
	logic signed [23:0] days_s4;
	logic signed [51:0] tp_s5;
	logic signed [51:0] tot_s6;
	logic [47:0] ep_s7;
	logic [47:0] ep_dly_q [DLY];

	// months 0..2 count as the tail of the previous computational year
	assign le2 = (month <= 4'd2);
	assign mi  = le2 ? month + 4'd9 : month - 4'd3;

	always_ff @(posedge clk) begin
		// s1: year biased by one era so every division stays unsigned
		y2_s1   <= 15'(year) + 15'(ecdc_pkg::ERA_YEARS) - 15'(le2);
		doyp_s1 <= ecdc_pkg::doy_start(mi) + 9'(day);
		hms_s1  <= 27'(hour) * 27'(ecdc_pkg::MS_PER_HOUR);
		mms_s1  <= 22'(minute) * 22'(ecdc_pkg::MS_PER_MIN);
		sms_s1  <= 16'(second) * 16'(ecdc_pkg::MS_PER_SEC);

		// s2
		cp_s2   <= 31'(y2_s1) * 31'(ecdc_pkg::CIV100_M);
		base_s2 <= 23'(y2_s1) * 23'(ecdc_pkg::YEAR_DAYS);
		y4_s2   <= y2_s1[14:2];
		doyp_s2 <= doyp_s1;
		tod_s2  <= hms_s1 + 27'(mms_s1) + 27'(sms_s1);

		// s3
		c_s3   <= cp_s2[ecdc_pkg::CIV100_K +: 8];
		pre_s3 <= base_s2 + 23'(y4_s2) + 23'(doyp_s2);
		tod_s3 <= tod_s2;

		// s4: y/400 is (y/100)/4; two's complement wrap gives the signed count
		days_s4 <= 24'(pre_s3) - 24'(c_s3) + 24'(c_s3[7:2]) - 24'(ecdc_pkg::DAY_BIAS);
		tod_s4  <= tod_s3;

		// s5
		tp_s5  <= 52'(days_s4) * 52'(MS_PER_DAY_S);
		tod_s5 <= tod_s4;

		// s6
		tot_s6 <= tp_s5 + $signed({25'd0, tod_s5});

		// s7: clamp to the 48-bit range
		if (tot_s6[51]) begin
			ep_s7 <= '0;
		end else if (|tot_s6[50:48]) begin
			ep_s7 <= '1;
		end else begin
			ep_s7 <= tot_s6[47:0];
		end

		// s8..s15
		ep_dly_q[0] <= ep_s7;
		for (int i = 1; i < DLY; i++) begin
			ep_dly_q[i] <= ep_dly_q[i-1];
		end
	end

	assign epoch = ep_dly_q[DLY-1];

endmodule

/* hdl/epoch_ms_civil_date_converter.sv */
// done marks the result of each start beat; both directions share one valid pipeline.
// Throughput: one beat per cycle; busy is never raised.
// The depth is set by the epoch-to-civil chain of reciprocal multiplies.
// Results are strobed on done for one cycle; the receiver cannot stall.
// Reset clears only the valid pipeline; datapath registers are not reset.
// ============================================================================
// epoch_ms_civil_date_converter - epoch ms <-> proleptic Gregorian civil time
// op selects the direction; fields the op does not produce read zero.
// ============================================================================
module epoch_ms_civil_date_converter (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  ecdc_pkg::cmd_t   cmd,
	output logic             done,
	output ecdc_pkg::rsp_t   rsp
);

	localparam int unsigned LAT = ecdc_pkg::LATENCY;

	logic [LAT-1:0] stg_vld_q;
	logic [LAT-1:0] stg_op_q;
	logic           take;

	logic [13:0] c_year;
	logic [3:0]  c_month;
	logic [4:0]  c_day;
	logic [4:0]  c_hour;
	logic [5:0]  c_minute;
	logic [5:0]  c_second;
	logic [2:0]  c_weekday;
	logic [47:0] e_epoch;
	logic        op_out;

	assign busy = 1'b0;
	assign take = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_vld_q <= '0;
		end else begin
			stg_vld_q <= {stg_vld_q[LAT-2:0], take};
		end
	end

	always_ff @(posedge clk) begin
		stg_op_q <= {stg_op_q[LAT-2:0], cmd.op};
	end

	ecdc_to_civil u_to_civil (
		.clk      (clk),
		.epoch_ms (cmd.epoch_ms_in),
		.year     (c_year),
		.month    (c_month),
		.day      (c_day),
		.hour     (c_hour),
		.minute   (c_minute),
		.second   (c_second),
		.weekday  (c_weekday)
	);

	ecdc_to_epoch u_to_epoch (
		.clk    (clk),
		.year   (cmd.year_in),
		.month  (cmd.month_in),
		.day    (cmd.day_in),
		.hour   (cmd.hour_in),
		.minute (cmd.minute_in),
		.second (cmd.second_in),
		.epoch  (e_epoch)
	);

	assign op_out = stg_op_q[LAT-1];
	assign done   = stg_vld_q[LAT-1];

	always_comb begin
		rsp = '0;
		case (op_out)
			ecdc_pkg::OP_TO_CIVIL: begin
				rsp.year_out    = c_year;
				rsp.month_out   = c_month;
				rsp.day_out     = c_day;
				rsp.hour_out    = c_hour;
				rsp.minute_out  = c_minute;
				rsp.second_out  = c_second;
				rsp.weekday_out = c_weekday;
			end
			ecdc_pkg::OP_TO_EPOCH: begin
				rsp.epoch_ms_out = e_epoch;
			end
			default: begin
				rsp = '0;
			end
		endcase
	end

endmodule
